@@ hdl/mtep_pkg.sv @@
// Shared types and constants for the MIDI track event parser.
`timescale 1ns / 1ps

package mtep_pkg;

  localparam logic [7:0] META_STATUS  = 8'hFF;
  localparam logic [7:0] SYSEX_START  = 8'hF0;
  localparam logic [7:0] SYSEX_ESCAPE = 8'hF7;
  localparam logic [3:0] CMD_PROGRAM  = 4'hC;
  localparam logic [3:0] CMD_PRESSURE = 4'hD;
  localparam int         VLQ_BITS     = 7;
  localparam int         CONT_BIT     = 7;

  // Both queues are this deep.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    REC_CHANNEL   = 2'd0,
    REC_META_HDR  = 2'd1,
    REC_META_DATA = 2'd2,
    REC_TRUNC     = 2'd3
  } rec_kind_t;

  // One track byte with its classification from the front end.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_meta;
    logic       is_sysex;
    logic       is_status;
  } byte_beat_t;

  typedef struct packed {
    rec_kind_t   kind;
    logic [31:0] delta_time;
    logic [3:0]  command;
    logic [3:0]  midi_channel;
    logic [7:0]  param_one;
    logic [7:0]  param_two;
    logic        running_used;
    logic [7:0]  meta_type;
    logic [31:0] meta_length;
    logic [7:0]  payload_byte;
    logic        payload_last;
  } result_t;

  function automatic logic [QPTR_W-1:0] qptr_inc(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QDEPTH - 1)) begin
      return '0;
    end
    return p + QPTR_W'(1);
  endfunction

endpackage

@@ hdl/mtep_front.sv @@
// Front end: classifies incoming track bytes and queues them for the parser.
`timescale 1ns / 1ps

module mtep_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_data_byte,
  input  logic               in_track_last,
  output logic               beat_valid,
  output mtep_pkg::byte_beat_t beat,
  input  logic               beat_take
);
  import mtep_pkg::*;

  byte_beat_t        mem_r [QDEPTH];
  byte_beat_t        incoming;
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_wr, do_rd;

  always_comb begin
    incoming.data      = in_data_byte;
    incoming.last      = in_track_last;
    incoming.is_meta   = (in_data_byte == META_STATUS);
    incoming.is_sysex  = (in_data_byte == SYSEX_START) || (in_data_byte == SYSEX_ESCAPE);
    incoming.is_status = in_data_byte[CONT_BIT];
  end

  assign in_full    = (count_r == QCNT_W'(QDEPTH));
  assign beat_valid = (count_r != '0);
  assign beat       = mem_r[rd_ptr_r];
  assign do_wr      = in_push && !in_full;
  assign do_rd      = beat_take && beat_valid;

  always_comb begin
    wr_ptr_nxt = do_wr ? qptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? qptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= incoming;
    end
  end

endmodule

@@ hdl/mtep_back.sv @@
// Back end: event parser FSM, one queued byte per cycle when res_full is low.
`timescale 1ns / 1ps

module mtep_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data,
  input  logic                 beat_valid,
  input  mtep_pkg::byte_beat_t beat,
  output logic                 beat_take,
  output logic                 res_push,
  output mtep_pkg::result_t    res,
  input  logic                 res_full
);
  import mtep_pkg::*;

  typedef enum logic [3:0] {
    PH_DELTA_FIRST,
    PH_DELTA_MORE,
    PH_STATUS,
    PH_PARAM1,
    PH_PARAM2,
    PH_META_TYPE,
    PH_META_LEN,
    PH_META_DATA,
    PH_SYX_LEN,
    PH_SYX_DATA
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic        short_cfg_r, short_cfg_nxt;
  logic [31:0] accum_r, accum_nxt;
  logic [31:0] delta_r, delta_nxt;
  logic [31:0] remain_r, remain_nxt;
  logic [7:0]  mtype_r, mtype_nxt;
  logic [7:0]  p1_r, p1_nxt;
  logic [3:0]  run_cmd_r, run_cmd_nxt;
  logic [3:0]  run_ch_r, run_ch_nxt;
  logic [3:0]  cur_cmd_r, cur_cmd_nxt;
  logic [3:0]  cur_ch_r, cur_ch_nxt;
  logic        cur_run_r, cur_run_nxt;
  logic        emit;
  result_t     rec;
  logic [31:0] shifted;
  logic [31:0] remain_dec;
  logic [7:0]  b;

  assign cfg_ready = 1'b1;
  assign beat_take = beat_valid && !res_full;
  assign b         = beat.data;

  always_comb begin
    short_cfg_nxt = (cfg_valid && cfg_ready) ? cfg_data : short_cfg_r;
    phase_nxt     = phase_r;
    accum_nxt     = accum_r;
    delta_nxt     = delta_r;
    remain_nxt    = remain_r;
    mtype_nxt     = mtype_r;
    p1_nxt        = p1_r;
    run_cmd_nxt   = run_cmd_r;
    run_ch_nxt    = run_ch_r;
    cur_cmd_nxt   = cur_cmd_r;
    cur_ch_nxt    = cur_ch_r;
    cur_run_nxt   = cur_run_r;
    emit          = 1'b0;
    rec           = '0;
    shifted       = {accum_r[31-VLQ_BITS:0], b[VLQ_BITS-1:0]};
    remain_dec    = remain_r - 32'd1;

    if (beat_take) begin
      case (phase_r)
        PH_STATUS: begin
          if (beat.is_meta) begin
            phase_nxt = PH_META_TYPE;
          end else if (beat.is_sysex) begin
            accum_nxt = '0;
            phase_nxt = PH_SYX_LEN;
          end else if (beat.is_status) begin
            cur_cmd_nxt = b[7:4];
            cur_ch_nxt  = b[3:0];
            cur_run_nxt = 1'b0;
            phase_nxt   = PH_PARAM1;
          end else begin
            cur_cmd_nxt = run_cmd_r;
            cur_ch_nxt  = run_ch_r;
            cur_run_nxt = 1'b1;
            p1_nxt      = b;
            phase_nxt   = PH_PARAM2;
            if (short_cfg_r && (run_cmd_r == CMD_PROGRAM || run_cmd_r == CMD_PRESSURE)) begin
              emit      = 1'b1;
              phase_nxt = PH_DELTA_FIRST;
            end
          end
        end
        PH_PARAM1: begin
          p1_nxt    = b;
          phase_nxt = PH_PARAM2;
          if (short_cfg_r && (cur_cmd_r == CMD_PROGRAM || cur_cmd_r == CMD_PRESSURE)) begin
            emit      = 1'b1;
            phase_nxt = PH_DELTA_FIRST;
          end
        end
        PH_PARAM2: begin
          emit      = 1'b1;
          phase_nxt = PH_DELTA_FIRST;
        end
        PH_META_TYPE: begin
          mtype_nxt = b;
          accum_nxt = '0;
          phase_nxt = PH_META_LEN;
        end
        PH_META_LEN: begin
          accum_nxt = shifted;
          if (!b[CONT_BIT]) begin
            emit             = 1'b1;
            rec.kind         = REC_META_HDR;
            rec.delta_time   = delta_r;
            rec.meta_type    = mtype_r;
            rec.meta_length  = shifted;
            remain_nxt       = shifted;
            phase_nxt        = (shifted == '0) ? PH_DELTA_FIRST : PH_META_DATA;
          end
        end
        PH_META_DATA: begin
          remain_nxt        = remain_dec;
          emit              = 1'b1;
          rec.kind          = REC_META_DATA;
          rec.delta_time    = delta_r;
          rec.meta_type     = mtype_r;
          rec.payload_byte  = b;
          rec.payload_last  = (remain_dec == '0);
          if (remain_dec == '0) begin
            phase_nxt = PH_DELTA_FIRST;
          end
        end
        PH_SYX_LEN: begin
          accum_nxt = shifted;
          if (!b[CONT_BIT]) begin
            remain_nxt = shifted;
            phase_nxt  = (shifted == '0) ? PH_DELTA_FIRST : PH_SYX_DATA;
          end
        end
        PH_SYX_DATA: begin
          remain_nxt = remain_dec;
          if (remain_dec == '0) begin
            phase_nxt = PH_DELTA_FIRST;
          end
        end
        default: begin
          // A fresh delta starts from zero; a continuation byte extends it.
          if (phase_r != PH_DELTA_MORE) begin
            shifted = {25'd0, b[VLQ_BITS-1:0]};
          end
          accum_nxt = shifted;
          if (b[CONT_BIT]) begin
            phase_nxt = PH_DELTA_MORE;
          end else begin
            delta_nxt = shifted;
            phase_nxt = PH_STATUS;
          end
        end
      endcase

      // Channel events carry the current command, which becomes the running one.
      if (emit && (phase_r == PH_STATUS || phase_r == PH_PARAM1 || phase_r == PH_PARAM2)) begin
        rec.kind         = REC_CHANNEL;
        rec.delta_time   = delta_r;
        rec.command      = cur_cmd_nxt;
        rec.midi_channel = cur_ch_nxt;
        rec.param_one    = (phase_r == PH_PARAM2) ? p1_r : b;
        rec.param_two    = (phase_r == PH_PARAM2) ? b : 8'd0;
        rec.running_used = cur_run_nxt;
        run_cmd_nxt      = cur_cmd_nxt;
        run_ch_nxt       = cur_ch_nxt;
      end

      if (beat.last) begin
        if (phase_nxt != PH_DELTA_FIRST) begin
          emit     = 1'b1;
          rec      = '0;
          rec.kind = REC_TRUNC;
        end
        phase_nxt   = PH_DELTA_FIRST;
        accum_nxt   = '0;
        run_cmd_nxt = '0;
        run_ch_nxt  = '0;
      end
    end
  end

  assign res_push = emit;
  assign res      = rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_DELTA_FIRST;
      short_cfg_r <= 1'b1;
      accum_r     <= '0;
      delta_r     <= '0;
      remain_r    <= '0;
      mtype_r     <= '0;
      p1_r        <= '0;
      run_cmd_r   <= '0;
      run_ch_r    <= '0;
      cur_cmd_r   <= '0;
      cur_ch_r    <= '0;
      cur_run_r   <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      short_cfg_r <= short_cfg_nxt;
      accum_r     <= accum_nxt;
      delta_r     <= delta_nxt;
      remain_r    <= remain_nxt;
      mtype_r     <= mtype_nxt;
      p1_r        <= p1_nxt;
      run_cmd_r   <= run_cmd_nxt;
      run_ch_r    <= run_ch_nxt;
      cur_cmd_r   <= cur_cmd_nxt;
      cur_ch_r    <= cur_ch_nxt;
      cur_run_r   <= cur_run_nxt;
    end
  end

  a_trunc_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res.kind == REC_TRUNC) |-> (beat_take && beat.last))
    else $error("truncation result without a final track byte");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (beat_take && beat.last) |=> (phase_r == PH_DELTA_FIRST && run_cmd_r == '0))
    else $error("parser not idle after the final track byte");

  a_payload_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res.kind == REC_META_DATA && res.payload_last) |=> (phase_r == PH_DELTA_FIRST))
    else $error("meta payload continued past its last byte");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result produced while the result queue is full");

endmodule

@@ hdl/mtep_resq.sv @@
// Result queue between the parser and the output ports.
`timescale 1ns / 1ps

module mtep_resq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_push,
  input  mtep_pkg::result_t res,
  output logic              res_full,
  output logic              out_empty,
  input  logic              out_pop,
  output mtep_pkg::result_t head
);
  import mtep_pkg::*;

  result_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_wr, do_rd;

  assign res_full  = (count_r == QCNT_W'(QDEPTH));
  assign out_empty = (count_r == '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_wr     = res_push && !res_full;
  assign do_rd     = out_pop && !out_empty;

  always_comb begin
    wr_ptr_nxt = do_wr ? qptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? qptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= res;
    end
  end

endmodule

@@ hdl/midi_track_event_parser.sv @@
// Top level of the MIDI track event parser: front queue, parser, result queue.
// Path: the front queue holds each byte until the parser takes it, when the
// result queue has room; any result goes into the result queue, whose head
// drives the out_ ports. Throughput: one track byte per cycle unless the
// result queue is full, set by the parser's single phase update and shift-add
// per byte; each byte yields zero or one result beat.
// Reset (rst_n low, synchronous) empties both queues, idles the parser and sets
// the short-command bit to 1.
`timescale 1ns / 1ps

module midi_track_event_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_track_last,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_rec_kind,
  output logic [31:0] out_delta_time,
  output logic [3:0]  out_command,
  output logic [3:0]  out_midi_channel,
  output logic [7:0]  out_param_one,
  output logic [7:0]  out_param_two,
  output logic        out_running_used,
  output logic [7:0]  out_meta_type,
  output logic [31:0] out_meta_length,
  output logic [7:0]  out_payload_byte,
  output logic        out_payload_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);
  import mtep_pkg::*;

  byte_beat_t beat;
  logic       beat_valid;
  logic       beat_take;
  result_t    res;
  logic       res_push;
  logic       res_full;
  result_t    head;

  mtep_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_data_byte  (in_data_byte),
    .in_track_last (in_track_last),
    .beat_valid    (beat_valid),
    .beat          (beat),
    .beat_take     (beat_take)
  );

  mtep_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .beat_valid (beat_valid),
    .beat       (beat),
    .beat_take  (beat_take),
    .res_push   (res_push),
    .res        (res),
    .res_full   (res_full)
  );

  mtep_resq u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .head      (head)
  );

  assign out_rec_kind     = head.kind;
  assign out_delta_time   = head.delta_time;
  assign out_command      = head.command;
  assign out_midi_channel = head.midi_channel;
  assign out_param_one    = head.param_one;
  assign out_param_two    = head.param_two;
  assign out_running_used = head.running_used;
  assign out_meta_type    = head.meta_type;
  assign out_meta_length  = head.meta_length;
  assign out_payload_byte = head.payload_byte;
  assign out_payload_last = head.payload_last;

endmodule
